@@ design/ast_pkg.sv @@
// Shared types, constants and lookup functions for the assembly tokenizer.
`timescale 1ns / 1ps
package ast_pkg;

   localparam int KEYWORD_BYTES = 8;
   localparam int COUNT_BITS    = 16;
   localparam int MAX_RECS      = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int KW_IDX_BITS   = $clog2(KEYWORD_BYTES);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // record types
   localparam logic [1:0] RT_VALUE = 2'd0;
   localparam logic [1:0] RT_END   = 2'd1;
   localparam logic [1:0] RT_STOP  = 2'd2;
   localparam logic [1:0] RT_EOT   = 2'd3;

   // lexer modes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_COMMENT = 4'd1;
   localparam logic [3:0] M_WORD    = 4'd2;
   localparam logic [3:0] M_NUMF    = 4'd3;
   localparam logic [3:0] M_DEC     = 4'd4;
   localparam logic [3:0] M_HEX     = 4'd5;
   localparam logic [3:0] M_BIN     = 4'd6;
   localparam logic [3:0] M_CFIRST  = 4'd7;
   localparam logic [3:0] M_CESC    = 4'd8;
   localparam logic [3:0] M_CCLOSE  = 4'd9;
   localparam logic [3:0] M_STR     = 4'd10;
   localparam logic [3:0] M_SESC    = 4'd11;
   localparam logic [3:0] M_HALT    = 4'd12;

   // token kinds used by name
   localparam logic [4:0] K_UNKNOWN   = 5'd0;
   localparam logic [4:0] K_INSTR     = 5'd1;
   localparam logic [4:0] K_TIMES     = 5'd2;
   localparam logic [4:0] K_DATA      = 5'd3;
   localparam logic [4:0] K_LABEL     = 5'd4;
   localparam logic [4:0] K_STRING    = 5'd5;
   localparam logic [4:0] K_CHAR      = 5'd6;
   localparam logic [4:0] K_DEC       = 5'd7;
   localparam logic [4:0] K_HEX       = 5'd8;
   localparam logic [4:0] K_BIN       = 5'd9;
   localparam logic [4:0] K_COMMA     = 5'd10;
   localparam logic [4:0] K_REGISTER  = 5'd11;
   localparam logic [4:0] K_PLUS      = 5'd12;
   localparam logic [4:0] K_MINUS     = 5'd13;
   localparam logic [4:0] K_STAR      = 5'd14;
   localparam logic [4:0] K_SLASH     = 5'd15;
   localparam logic [4:0] K_PIPE      = 5'd16;
   localparam logic [4:0] K_CARET     = 5'd17;
   localparam logic [4:0] K_AMP       = 5'd18;
   localparam logic [4:0] K_TILDE     = 5'd19;
   localparam logic [4:0] K_LPAREN    = 5'd20;
   localparam logic [4:0] K_RPAREN    = 5'd21;
   localparam logic [4:0] K_NEWLINE   = 5'd22;
   localparam logic [4:0] K_BACKSLASH = 5'd23;
   localparam logic [4:0] K_INCLUDE   = 5'd24;
   localparam logic [4:0] K_DEFINE    = 5'd25;
   localparam logic [4:0] K_IF        = 5'd26;
   localparam logic [4:0] K_IFDEF     = 5'd27;
   localparam logic [4:0] K_IFNDEF    = 5'd28;
   localparam logic [4:0] K_ELSE      = 5'd29;
   localparam logic [4:0] K_ENDIF     = 5'd30;

   localparam logic [0:0] CAUSE_STRING = 1'b0;
   localparam logic [0:0] CAUSE_CHAR   = 1'b1;

   typedef struct packed {
      logic [1:0]  rtype;
      logic [7:0]  value;
      logic [4:0]  kind;
      logic        cause;
      logic [15:0] line;
      logic [15:0] column;
      logic [15:0] length;
   } rec_type;

   typedef rec_type [MAX_RECS-1:0] rec_arr_type;

   // one byte's worth of results; cnt is number of records minus one
   typedef struct packed {
      rec_arr_type recs;
      logic [1:0]  cnt;
   } run_type;

   function automatic rec_type mk_rec(logic [1:0] rt, logic [7:0] v, logic [4:0] kind,
                                      logic cause, logic [15:0] ln, logic [15:0] col,
                                      logic [15:0] len);
      rec_type r;
      r.rtype  = rt;
      r.value  = v;
      r.kind   = kind;
      r.cause  = cause;
      r.line   = ln;
      r.column = col;
      r.length = len;
      return r;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] x);
      return (x != CNT_MAX) ? x + 1'b1 : x;
   endfunction

   // counter value as seen on the 16-bit output fields
   function automatic logic [15:0] clip16(logic [COUNT_BITS-1:0] x);
      return (x > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(x);
   endfunction

   function automatic logic is_break(logic [7:0] c);
      return c inside {"+", "*", "-", "/", " ", 8'h09, "\\", "|", "^", "&", "~", ",",
                       8'h0A, "(", ")"};
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
   endfunction

   // operator kind; valid flag in the MSB of the result
   function automatic logic [5:0] op_kind(logic [7:0] c);
      logic [5:0] r;
      case (c)
         ",":     r = {1'b1, K_COMMA};
         "+":     r = {1'b1, K_PLUS};
         "-":     r = {1'b1, K_MINUS};
         "*":     r = {1'b1, K_STAR};
         "/":     r = {1'b1, K_SLASH};
         "|":     r = {1'b1, K_PIPE};
         "^":     r = {1'b1, K_CARET};
         "&":     r = {1'b1, K_AMP};
         "~":     r = {1'b1, K_TILDE};
         "(":     r = {1'b1, K_LPAREN};
         ")":     r = {1'b1, K_RPAREN};
         default: r = {1'b0, K_UNKNOWN};
      endcase
      return r;
   endfunction

   // w holds the word right-aligned, first byte highest; word bytes are never zero
   function automatic logic [4:0] kw_kind(logic [8*KEYWORD_BYTES-1:0] w);
      logic [4:0] k;
      case (w)
         "times": k = K_TIMES;
         "db", "ds", "di", "dl": k = K_DATA;
         "stol", "stoi", "stos", "stob", "loal", "loai", "loas", "loab",
         "add", "sub", "mul", "div", "smul", "sdiv", "cmp",
         "adde", "addne", "addl", "addg", "addsl", "addsg",
         "pushl", "pushi", "pushs", "pushb", "popl", "popi", "pops", "popb",
         "call", "int", "iret", "and", "or", "xor", "not", "shl", "shr",
         "chst", "lost", "stolk", "loalk", "chtp", "lotp", "chflag", "loflag",
         "cint": k = K_INSTR;
         "r0", "r1", "r2", "r3", "r4", "r5", "r6", "r7", "r8", "r9",
         "r10", "r11", "r12", "r13", "r14", "r15", "sp", "pc": k = K_REGISTER;
         "#include": k = K_INCLUDE;
         "#define", "#undef": k = K_DEFINE;
         "#if": k = K_IF;
         "#ifdef": k = K_IFDEF;
         "#ifndef": k = K_IFNDEF;
         "#else": k = K_ELSE;
         "#endif": k = K_ENDIF;
         default: k = K_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

@@ design/ast_front.sv @@
// Lexer front end: takes one source byte a beat and builds its run of records.
`timescale 1ns / 1ps
module ast_front
   import ast_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  b,
   output logic        push,
   output run_type     run
);

   logic [3:0]  mode_ff, mode_in;
   logic [7:0]  hb_ff, hb_in;
   logic [KEYWORD_BYTES-1:0][7:0] pre_ff, pre_in;   // first word byte in the top byte
   logic [COUNT_BITS-1:0] cl_ff, cl_in, cc_ff, cc_in, sl_ff, sl_in, sc_ff, sc_in;
   logic [COUNT_BITS-1:0] vl_ff, vl_in, bl_ff, bl_in, bc_ff, bc_in;
   logic        bp_ff, bp_in;

   rec_arr_type recs;
   logic [2:0]  n;
   logic        go_idle;
   logic [COUNT_BITS-1:0] total;
   logic [4:0]  kind;
   logic [5:0]  opk;
   logic [KW_IDX_BITS+3:0] sh;

   function automatic rec_arr_type put(rec_arr_type a, logic [2:0] i, rec_type r);
      rec_arr_type o;
      o = a;
      if (i < 3'(MAX_RECS)) o[i[1:0]] = r;
      return o;
   endfunction

   function automatic logic [2:0] nxt(logic [2:0] i);
      return (i < 3'(MAX_RECS)) ? i + 3'd1 : i;
   endfunction

   always_comb begin
      mode_in = mode_ff; hb_in = hb_ff; pre_in = pre_ff;
      cl_in = cl_ff; cc_in = cc_ff; sl_in = sl_ff; sc_in = sc_ff;
      vl_in = vl_ff; bp_in = bp_ff; bl_in = bl_ff; bc_in = bc_ff;
      recs = '0; n = 3'd0; go_idle = 1'b0;
      total = '0; kind = K_UNKNOWN; sh = '0;
      opk = op_kind(b);

      case (mode_ff)
         M_HALT: ;
         M_WORD: begin
            if (b == 8'd0 || is_break(b)) begin
               total = sat_inc(vl_in);
               if (hb_in == ":") kind = K_LABEL;
               else begin
                  recs = put(recs, n, mk_rec(RT_VALUE, hb_in, '0, 1'b0, '0, '0, '0));
                  n = nxt(n); vl_in = sat_inc(vl_in);
                  if (total <= COUNT_BITS'(KEYWORD_BYTES)) begin
                     sh = {(KW_IDX_BITS+1)'(KEYWORD_BYTES) - total[KW_IDX_BITS:0], 3'b000};
                     kind = kw_kind(pre_in >> sh);
                  end
               end
               recs = put(recs, n, mk_rec(RT_END, '0, kind, 1'b0, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n);
               go_idle = 1'b1;
            end else begin
               recs = put(recs, n, mk_rec(RT_VALUE, hb_in, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
               if (vl_in < COUNT_BITS'(KEYWORD_BYTES))
                  pre_in[KW_IDX_BITS'(KEYWORD_BYTES-1) - vl_in[KW_IDX_BITS-1:0]] = b;
               hb_in = b;
            end
         end
         M_NUMF: begin
            if (b == "x" || b == "X") mode_in = M_HEX;
            else if (b == "b" || b == "B") mode_in = M_BIN;
            else begin
               recs = put(recs, n, mk_rec(RT_VALUE, hb_in, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
               if (is_digit(b)) begin
                  recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
                  n = nxt(n); vl_in = sat_inc(vl_in);
                  mode_in = M_DEC;
               end else begin
                  recs = put(recs, n, mk_rec(RT_END, '0, K_DEC, 1'b0, clip16(sl_in),
                                             clip16(sc_in), clip16(vl_in)));
                  n = nxt(n);
                  go_idle = 1'b1;
               end
            end
         end
         M_DEC, M_HEX, M_BIN: begin
            if ((mode_ff == M_DEC && is_digit(b)) || (mode_ff == M_HEX && is_hex(b)) ||
                (mode_ff == M_BIN && (b == "0" || b == "1"))) begin
               recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
            end else begin
               kind = (mode_ff == M_DEC) ? K_DEC : (mode_ff == M_HEX) ? K_HEX : K_BIN;
               recs = put(recs, n, mk_rec(RT_END, '0, kind, 1'b0, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n);
               go_idle = 1'b1;
            end
         end
         M_COMMENT: begin
            if (b == 8'h0A || b == 8'd0) go_idle = 1'b1;
         end
         M_CFIRST, M_CESC: begin
            if (b == 8'd0) begin
               recs = put(recs, n, mk_rec(RT_STOP, '0, K_CHAR, CAUSE_CHAR, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n); mode_in = M_HALT;
            end else begin
               recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
               mode_in = (mode_ff == M_CFIRST && b == "\\") ? M_CESC : M_CCLOSE;
            end
         end
         M_CCLOSE: begin
            if (b == "'") begin
               recs = put(recs, n, mk_rec(RT_END, '0, K_CHAR, 1'b0, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n); mode_in = M_IDLE;
            end else begin
               recs = put(recs, n, mk_rec(RT_STOP, '0, K_CHAR, CAUSE_CHAR, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n); mode_in = M_HALT;
            end
         end
         M_STR: begin
            if (b == "\"") begin
               recs = put(recs, n, mk_rec(RT_END, '0, K_STRING, 1'b0, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n); mode_in = M_IDLE;
            end else if (b == 8'd0 || b == 8'h0A) begin
               recs = put(recs, n, mk_rec(RT_STOP, '0, K_STRING, CAUSE_STRING, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n); mode_in = M_HALT;
            end else begin
               recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
               if (b == "\\") mode_in = M_SESC;
            end
         end
         M_SESC: begin
            if (b == 8'd0) begin
               recs = put(recs, n, mk_rec(RT_STOP, '0, K_STRING, CAUSE_STRING, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n); mode_in = M_HALT;
            end else begin
               recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
               mode_in = M_STR;
            end
         end
         default: go_idle = 1'b1;
      endcase

      // byte that lands between tokens (also the byte that ended a token)
      if (go_idle) begin
         mode_in = M_IDLE;
         if (b == 8'd0 || !(b == " " || b == 8'h09 || b == ";" || b == 8'h0A)) begin
            if (bp_in) begin
               bp_in = 1'b0;
               recs = put(recs, n, mk_rec(RT_VALUE, "\\", '0, 1'b0, '0, '0, '0));
               n = nxt(n);
               recs = put(recs, n, mk_rec(RT_END, '0, K_BACKSLASH, 1'b0, clip16(bl_in),
                                          clip16(bc_in), 16'd1));
               n = nxt(n);
            end
         end
         if (b == 8'd0) begin
            recs = put(recs, n, mk_rec(RT_EOT, '0, '0, 1'b0, clip16(cl_in), clip16(cc_in),
                                       '0));
            n = nxt(n);
         end else if (b == ";") begin
            mode_in = M_COMMENT;
         end else if (b == 8'h0A) begin
            if (bp_in) bp_in = 1'b0;
            else begin
               sl_in = cl_in; sc_in = cc_in; vl_in = '0;
               recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
               n = nxt(n); vl_in = sat_inc(vl_in);
               recs = put(recs, n, mk_rec(RT_END, '0, K_NEWLINE, 1'b0, clip16(sl_in),
                                          clip16(sc_in), clip16(vl_in)));
               n = nxt(n);
            end
         end else if (b == " " || b == 8'h09) begin
            mode_in = M_IDLE;
         end else if (is_digit(b)) begin
            sl_in = cl_in; sc_in = cc_in; vl_in = '0;
            hb_in = b; mode_in = M_NUMF;
         end else if (b == "'") begin
            sl_in = cl_in; sc_in = cc_in; vl_in = '0;
            mode_in = M_CFIRST;
         end else if (b == "\"") begin
            sl_in = cl_in; sc_in = cc_in; vl_in = '0;
            mode_in = M_STR;
         end else if (opk[5]) begin
            sl_in = cl_in; sc_in = cc_in; vl_in = '0;
            recs = put(recs, n, mk_rec(RT_VALUE, b, '0, 1'b0, '0, '0, '0));
            n = nxt(n); vl_in = sat_inc(vl_in);
            recs = put(recs, n, mk_rec(RT_END, '0, opk[4:0], 1'b0, clip16(sl_in),
                                       clip16(sc_in), clip16(vl_in)));
            n = nxt(n);
         end else if (b == "\\") begin
            bp_in = 1'b1; bl_in = cl_in; bc_in = cc_in;
         end else begin
            sl_in = cl_in; sc_in = cc_in; vl_in = '0;
            hb_in = b; pre_in[KEYWORD_BYTES-1] = b; mode_in = M_WORD;
         end
      end

      // positions; a zero byte starts a fresh text
      if (b == 8'd0) begin
         mode_in = M_IDLE; hb_in = '0; bp_in = 1'b0;
         cl_in = '0; cc_in = '0; sl_in = '0; sc_in = '0;
         vl_in = '0; bl_in = '0; bc_in = '0;
      end else if (mode_in != M_HALT) begin
         if (b == 8'h0A) begin
            cl_in = sat_inc(cl_in); cc_in = '0;
         end else begin
            cc_in = sat_inc(cc_in);
         end
      end
   end

   assign push     = take && (n != 3'd0);
   assign run.recs = recs;
   assign run.cnt  = 2'(n - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; hb_ff <= '0; bp_ff <= 1'b0;
         cl_ff <= '0; cc_ff <= '0; sl_ff <= '0; sc_ff <= '0;
         vl_ff <= '0; bl_ff <= '0; bc_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in; hb_ff <= hb_in; bp_ff <= bp_in;
         cl_ff <= cl_in; cc_ff <= cc_in; sl_ff <= sl_in; sc_ff <= sc_in;
         vl_ff <= vl_in; bl_ff <= bl_in; bc_ff <= bc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) pre_ff <= pre_in;
   end

endmodule

@@ design/ast_queue.sv @@
// Short queue of record runs between the lexer and the output serializer.
`timescale 1ns / 1ps
module ast_queue
   import ast_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_run,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output run_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   run_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff;

   assign full      = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_run;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

@@ design/ast_back.sv @@
// Output side: sends the records of each queued run one beat at a time.
`timescale 1ns / 1ps
module ast_back
   import ast_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  run_type q_head,
   output logic    pop,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rec_type rsp_rec,
   output logic    rsp_last
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   rec_type    rec_ff;
   logic       last_ff;
   logic       load;
   logic       is_last;

   assign load    = !valid_ff || !rsp_stall;
   assign is_last = (idx_ff == q_head.cnt);
   assign pop     = load && q_valid && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; idx_ff <= '0;
      end else if (load) begin
         valid_ff <= q_valid;
         if (q_valid) idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && q_valid) begin
         rec_ff  <= q_head.recs[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_rec   = rec_ff;
   assign rsp_last  = last_ff;

endmodule

@@ design/assembly_source_tokenizer_core.sv @@
// Top level of the assembly source tokenizer.
//
// Input channel req_: one source byte per beat (req_source_byte); a zero byte
// ends the text and resets line and column counts for the next one.
// Output channel rsp_: one record per beat: value bytes of a token, then a
// token end record with kind, start line, column and length; stop records
// for bad string or char literals, and an end of text record.
// rsp_last_of_run marks the last record that one source byte caused.
// A byte is taken by the lexer and its records (up to four) go into a
// four-entry queue; the output stage sends one record per cycle while
// rsp_stall is low, so throughput is one byte per cycle when a byte makes
// at most one record, and set by the output port otherwise. The first
// record of a byte passes through the queue and the output register to rsp_.
// req_stall rises only when the queue is full. A stalled record holds on
// rsp_ and later records wait in the queue. Synchronous reset empties the
// queue and output stage and returns the lexer to between-tokens state.
`timescale 1ns / 1ps
module assembly_source_tokenizer_core
   import ast_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_record_type,
   output logic [7:0]  rsp_value_byte,
   output logic [4:0]  rsp_token_kind,
   output logic        rsp_stop_cause,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   logic    full, take, push, not_empty, pop;
   run_type run, head;
   rec_type rec;

   assign req_stall = full;
   assign take      = req_valid && !full;

   ast_front u_front (
      .clock (clock), .reset (reset), .take (take), .b (req_source_byte),
      .push (push), .run (run)
   );

   ast_queue u_queue (
      .clock (clock), .reset (reset), .push (push), .push_run (run), .pop (pop),
      .full (full), .not_empty (not_empty), .head (head)
   );

   ast_back u_back (
      .clock (clock), .reset (reset), .q_valid (not_empty), .q_head (head), .pop (pop),
      .rsp_stall (rsp_stall), .rsp_valid (rsp_valid), .rsp_rec (rec),
      .rsp_last (rsp_last_of_run)
   );

   assign rsp_record_type  = rec.rtype;
   assign rsp_value_byte   = rec.value;
   assign rsp_token_kind   = rec.kind;
   assign rsp_stop_cause   = rec.cause;
   assign rsp_token_line   = rec.line;
   assign rsp_token_column = rec.column;
   assign rsp_token_length = rec.length;

endmodule

@@ dv/assembly_source_tokenizer_core_tb.sv @@
// Testbench for the assembly source tokenizer: directed and random source text, scoreboarded.
`timescale 1ns / 1ps
module assembly_source_tokenizer_core_tb;
   import ast_pkg::*;

   typedef struct {
      rec_type rec;
      logic    last;
   } tok_rec_type;

   typedef struct {
      logic [7:0] b;
      bit         typed;
      rec_type    rec;
   } drow_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_source_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_record_type;
   logic [7:0]  rsp_value_byte;
   logic [4:0]  rsp_token_kind;
   logic        rsp_stop_cause;
   logic [15:0] rsp_token_line;
   logic [15:0] rsp_token_column;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_run;

   assembly_source_tokenizer_core i_dut (.*);

   // lexer copy
   logic [3:0]  lx_mode = M_IDLE;
   logic [7:0]  held_b = 8'd0;
   logic [7:0]  prefix [KEYWORD_BYTES];
   logic [15:0] cur_ln = 0, cur_col = 0, st_ln = 0, st_col = 0, vlen = 0;
   logic        bs_pend = 1'b0;
   logic [15:0] bs_ln = 0, bs_col = 0;
   logic [4:0]  kw_map [string];
   string       kw_names [$];

   rec_type     step_recs [$];
   tok_rec_type tok_q [$];
   logic [7:0]  src_q [$];
   drow_type    drows [$];

   int errors = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] sinc(logic [15:0] x);
      return (x != 16'hFFFF) ? x + 16'd1 : x;
   endfunction

   function automatic void emit(logic [1:0] rt, logic [7:0] v, logic [4:0] k, logic c,
                                logic [15:0] ln, logic [15:0] col, logic [15:0] len);
      rec_type r;
      r.rtype = rt; r.value = v; r.kind = k; r.cause = c;
      r.line = ln; r.column = col; r.length = len;
      if (step_recs.size() < MAX_RECS) step_recs.push_back(r);
   endfunction

   function automatic void put_val(logic [7:0] b);
      emit(RT_VALUE, b, K_UNKNOWN, 1'b0, 16'd0, 16'd0, 16'd0);
      vlen = sinc(vlen);
   endfunction

   function automatic void begin_tok();
      st_ln = cur_ln; st_col = cur_col; vlen = 0;
   endfunction

   function automatic void end_tok(logic [4:0] k);
      emit(RT_END, 8'd0, k, 1'b0, st_ln, st_col, vlen);
      lx_mode = M_IDLE;
   endfunction

   function automatic void stop_lit(logic [4:0] k, logic c);
      emit(RT_STOP, 8'd0, k, c, st_ln, st_col, vlen);
      lx_mode = M_HALT;
   endfunction

   function automatic void flush_bs();
      if (!bs_pend) return;
      bs_pend = 1'b0;
      emit(RT_VALUE, "\\", K_UNKNOWN, 1'b0, 16'd0, 16'd0, 16'd0);
      emit(RT_END, 8'd0, K_BACKSLASH, 1'b0, bs_ln, bs_col, 16'd1);
   endfunction

   function automatic logic [4:0] op_code(logic [7:0] c);
      case (c)
         ",": return K_COMMA;
         "+": return K_PLUS;
         "-": return K_MINUS;
         "*": return K_STAR;
         "/": return K_SLASH;
         "|": return K_PIPE;
         "^": return K_CARET;
         "&": return K_AMP;
         "~": return K_TILDE;
         "(": return K_LPAREN;
         ")": return K_RPAREN;
         default: return K_UNKNOWN;
      endcase
   endfunction

   function automatic bit word_break(logic [7:0] c);
      return op_code(c) != K_UNKNOWN || c == " " || c == 8'h09 || c == "\\" || c == 8'h0A;
   endfunction

   function automatic logic [4:0] word_kind(logic [15:0] n);
      string s;
      s = "";
      if (n > KEYWORD_BYTES) return K_UNKNOWN;
      for (int i = 0; i < n; i++) s = {s, string'(prefix[i])};
      return kw_map.exists(s) ? kw_map[s] : K_UNKNOWN;
   endfunction

   function automatic void finish_word();
      logic [15:0] total;
      logic [4:0]  k;
      total = sinc(vlen);
      if (held_b == ":") k = K_LABEL;
      else begin
         put_val(held_b);
         k = word_kind(total);
      end
      end_tok(k);
   endfunction

   function automatic void idle_byte(logic [7:0] b);
      lx_mode = M_IDLE;
      if (b == 0) begin
         flush_bs();
         emit(RT_EOT, 8'd0, K_UNKNOWN, 1'b0, cur_ln, cur_col, 16'd0);
         return;
      end
      if (b == " " || b == 8'h09) return;
      if (b == ";") begin
         lx_mode = M_COMMENT;
         return;
      end
      if (b == 8'h0A) begin
         // backslash joins the line: both vanish
         if (bs_pend) begin
            bs_pend = 1'b0;
            return;
         end
         begin_tok(); put_val(b); end_tok(K_NEWLINE);
         return;
      end
      flush_bs();
      if (b >= "0" && b <= "9") begin
         begin_tok(); held_b = b; lx_mode = M_NUMF;
      end else if (b == "'") begin
         begin_tok(); lx_mode = M_CFIRST;
      end else if (b == "\"") begin
         begin_tok(); lx_mode = M_STR;
      end else if (op_code(b) != K_UNKNOWN) begin
         begin_tok(); put_val(b); end_tok(op_code(b));
      end else if (b == "\\") begin
         bs_pend = 1'b1; bs_ln = cur_ln; bs_col = cur_col;
      end else begin
         begin_tok(); held_b = b; prefix[0] = b; lx_mode = M_WORD;
      end
   endfunction

   function automatic bit hex_digit(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // runs one source byte through the lexer copy; results land in step_recs
   function automatic void lex_byte(logic [7:0] b);
      step_recs.delete();
      case (lx_mode)
         M_HALT: ;
         M_WORD:
            if (b == 0 || word_break(b)) begin
               finish_word(); idle_byte(b);
            end else begin
               put_val(held_b);
               if (vlen < KEYWORD_BYTES) prefix[vlen] = b;
               held_b = b;
            end
         M_NUMF:
            if (b == "x" || b == "X") lx_mode = M_HEX;
            else if (b == "b" || b == "B") lx_mode = M_BIN;
            else if (b >= "0" && b <= "9") begin
               put_val(held_b); put_val(b); lx_mode = M_DEC;
            end else begin
               put_val(held_b); end_tok(K_DEC); idle_byte(b);
            end
         M_DEC:
            if (b >= "0" && b <= "9") put_val(b);
            else begin
               end_tok(K_DEC); idle_byte(b);
            end
         M_HEX:
            if (hex_digit(b)) put_val(b);
            else begin
               end_tok(K_HEX); idle_byte(b);
            end
         M_BIN:
            if (b == "0" || b == "1") put_val(b);
            else begin
               end_tok(K_BIN); idle_byte(b);
            end
         M_COMMENT:
            if (b == 8'h0A || b == 0) idle_byte(b);
         M_CFIRST:
            if (b == 0) stop_lit(K_CHAR, CAUSE_CHAR);
            else begin
               put_val(b); lx_mode = (b == "\\") ? M_CESC : M_CCLOSE;
            end
         M_CESC:
            if (b == 0) stop_lit(K_CHAR, CAUSE_CHAR);
            else begin
               put_val(b); lx_mode = M_CCLOSE;
            end
         M_CCLOSE:
            if (b == "'") end_tok(K_CHAR);
            else stop_lit(K_CHAR, CAUSE_CHAR);
         M_STR:
            if (b == "\"") end_tok(K_STRING);
            else if (b == 0 || b == 8'h0A) stop_lit(K_STRING, CAUSE_STRING);
            else begin
               put_val(b);
               if (b == "\\") lx_mode = M_SESC;
            end
         M_SESC:
            if (b == 0) stop_lit(K_STRING, CAUSE_STRING);
            else begin
               put_val(b); lx_mode = M_STR;
            end
         default: idle_byte(b);
      endcase
      if (b == 0) begin
         lx_mode = M_IDLE; held_b = 0; bs_pend = 1'b0;
         cur_ln = 0; cur_col = 0; st_ln = 0; st_col = 0; vlen = 0; bs_ln = 0; bs_col = 0;
      end else if (lx_mode != M_HALT) begin
         if (b == 8'h0A) begin
            cur_ln = sinc(cur_ln); cur_col = 0;
         end else cur_col = sinc(cur_col);
      end
      foreach (step_recs[i]) tok_q.push_back('{step_recs[i], i == step_recs.size() - 1});
   endfunction

   function automatic void add_kws(string s, logic [4:0] k);
      string w;
      w = "";
      for (int i = 0; i <= s.len(); i++) begin
         if (i == s.len() || s[i] == " ") begin
            if (w.len() > 0) begin
               kw_map[w] = k;
               kw_names.push_back(w);
            end
            w = "";
         end else w = {w, string'(s[i])};
      end
   endfunction

   initial begin
      add_kws("times", K_TIMES);
      add_kws("db ds di dl", K_DATA);
      add_kws({"stol stoi stos stob loal loai loas loab add sub mul div smul sdiv cmp ",
               "adde addne addl addg addsl addsg pushl pushi pushs pushb popl popi pops ",
               "popb call int iret and or xor not shl shr chst lost stolk loalk chtp ",
               "lotp chflag loflag cint"}, K_INSTR);
      add_kws("r0 r1 r2 r3 r4 r5 r6 r7 r8 r9 r10 r11 r12 r13 r14 r15 sp pc", K_REGISTER);
      add_kws("#include", K_INCLUDE);
      add_kws("#define #undef", K_DEFINE);
      add_kws("#if", K_IF);
      add_kws("#ifdef", K_IFDEF);
      add_kws("#ifndef", K_IFNDEF);
      add_kws("#else", K_ELSE);
      add_kws("#endif", K_ENDIF);
   end

   // result side: stall pattern and long hold-off
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_stall = 1'b1;
            hold_cnt--;
         end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_cnt = 120;
            rsp_stall = 1'b1;
         end else rsp_stall = ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      tok_rec_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tok_q.size() == 0) begin
            $error("unexpected record type %0d", rsp_record_type);
            errors++;
         end else begin
            e = tok_q.pop_front();
            if (rsp_record_type !== e.rec.rtype) begin
               $error("record_type exp %0d got %0d", e.rec.rtype, rsp_record_type); errors++;
            end
            if (rsp_value_byte !== e.rec.value) begin
               $error("value_byte exp %0h got %0h", e.rec.value, rsp_value_byte); errors++;
            end
            if (rsp_token_kind !== e.rec.kind) begin
               $error("token_kind exp %0d got %0d", e.rec.kind, rsp_token_kind); errors++;
            end
            if (rsp_stop_cause !== e.rec.cause) begin
               $error("stop_cause exp %0d got %0d", e.rec.cause, rsp_stop_cause); errors++;
            end
            if (rsp_token_line !== e.rec.line) begin
               $error("token_line exp %0d got %0d", e.rec.line, rsp_token_line); errors++;
            end
            if (rsp_token_column !== e.rec.column) begin
               $error("token_column exp %0d got %0d", e.rec.column, rsp_token_column);
               errors++;
            end
            if (rsp_token_length !== e.rec.length) begin
               $error("token_length exp %0d got %0d", e.rec.length, rsp_token_length);
               errors++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run exp %0d got %0d", e.last, rsp_last_of_run); errors++;
            end
         end
      end
   end

   task automatic send_byte(logic [7:0] b, bit typed, rec_type want);
      req_source_byte = b;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      lex_byte(b);
      if (typed && step_recs.size() == 0) begin
         $error("directed beat %0h: first record exp %p got none", b, want);
         errors++;
      end else if (typed && step_recs[0] != want) begin
         $error("directed beat %0h: first record exp %p got %p", b, want, step_recs[0]);
         errors++;
      end
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_source_byte = 8'($urandom_range(255));
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   function automatic void add_str(string s);
      foreach (s[i]) src_q.push_back(s[i]);
   endfunction

   function automatic void add_drow(string s);
      foreach (s[i]) drows.push_back('{s[i], 1'b0, '0});
   endfunction

   function automatic string rand_chars(int n, string pool);
      string s;
      s = "";
      repeat (n) s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
      return s;
   endfunction

   // random source text of roughly n bytes, ended by a zero byte
   function automatic void gen_text(int n);
      string lc, ops;
      int start;
      lc = "abcdefghijklmnopqrstuvwxyz_.#";
      ops = ",+-*/|^&~()";
      start = src_q.size();
      while (src_q.size() - start < n) begin
         case ($urandom_range(13))
            0, 1: add_str(kw_names[$urandom_range(kw_names.size() - 1)]);
            2: add_str(rand_chars($urandom_range(1, 11), lc));
            3: add_str({rand_chars($urandom_range(1, 6), lc), ":"});
            4: add_str(rand_chars($urandom_range(1, 5), "0123456789"));
            5: add_str({"0", ($urandom_range(1) ? "x" : "X"),
                        rand_chars($urandom_range(0, 4), "0123456789abcdefABCDEFg")});
            6: add_str({"1", ($urandom_range(1) ? "b" : "B"),
                        rand_chars($urandom_range(0, 5), "0102")});
            7: begin
               add_str("'");
               if ($urandom_range(3) == 0) add_str({"\\", rand_chars(1, "n0t'")});
               else src_q.push_back(8'($urandom_range(1, 255)));
               if ($urandom_range(9) != 0) add_str("'");
            end
            8: begin
               add_str({"\"", rand_chars($urandom_range(0, 6), "ab \\;'x")});
               if ($urandom_range(9) != 0) add_str("\"");
               else add_str("\n");
            end
            9: add_str({";", rand_chars($urandom_range(0, 6), "ab ;\"'"), "\n"});
            10: add_str(rand_chars(1, ops));
            11: add_str(rand_chars(1, " \t\n"));
            12: add_str({"\\", rand_chars($urandom_range(0, 2), " \t;"), "\n"});
            default: src_q.push_back(8'($urandom_range(1, 255)));
         endcase
         if ($urandom_range(1)) add_str(rand_chars(1, " ,+\n"));
         if ($urandom_range(59) == 0) src_q.push_back(8'd0);
      end
      src_q.push_back(8'd0);
   endfunction

   initial begin
      rec_type r_eot, r_stop;
      int gap;
      reset = 1'b1;
      req_valid = 1'b0;
      req_source_byte = 8'd0;
      r_eot = '{RT_EOT, 8'd0, K_UNKNOWN, 1'b0, 16'd0, 16'd0, 16'd0};
      // "'ab": quote at column 0, one value byte kept
      r_stop = '{RT_STOP, 8'd0, K_CHAR, CAUSE_CHAR, 16'd0, 16'd0, 16'd1};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 29;
      rcv_idle_pct = 79;
      drows.push_back('{8'd0, 1'b1, r_eot});
      drows.push_back('{"'", 1'b0, '0});
      drows.push_back('{"a", 1'b0, '0});
      drows.push_back('{"b", 1'b1, r_stop});
      add_drow("q");
      drows.push_back('{8'd0, 1'b0, '0});
      add_drow("pc,0x1F;c\n\\ \nl:'\\n'\"s\\\"\"0b2 7(9)\377");
      drows.push_back('{8'd0, 1'b0, '0});
      foreach (drows[i]) send_byte(drows[i].b, drows[i].typed, drows[i].rec);

      // let the tokenizer drain before random text
      req_valid = 1'b0;
      wait (tok_q.size() == 0);
      @(negedge clock);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 79 : 0;
         rcv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 29 : 0;
         if (ph == 2) hold_req++;
         src_q.delete();
         gen_text(42);
         foreach (src_q[i]) send_byte(src_q[i], 1'b0, '0);
      end
      req_valid = 1'b0;

      wait (tok_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
design/ast_pkg.sv
design/ast_front.sv
design/ast_queue.sv
design/ast_back.sv
design/assembly_source_tokenizer_core.sv
dv/assembly_source_tokenizer_core_tb.sv
